// ===== hdl/fprx_pkg.sv =====
// Shared types, codes and the CRC-32 byte update for the packet receiver.
package fprx_pkg;

   localparam int unsigned MAX_PAYLOAD_DEFAULT = 1024;

   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 11;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_START_BYTE   = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_END_BYTE     = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LENGTH_LIMIT = 2'd2;

   localparam logic [7:0]  START_BYTE_RESET   = 8'd170;
   localparam logic [7:0]  END_BYTE_RESET     = 8'd187;
   localparam logic [10:0] LENGTH_LIMIT_RESET = 11'd1024;

   localparam logic [1:0] KIND_DATA   = 2'd0;
   localparam logic [1:0] KIND_ACCEPT = 2'd1;
   localparam logic [1:0] KIND_REJECT = 2'd2;

   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_START = 3'd1;
   localparam logic [2:0] ERR_END   = 3'd2;
   localparam logic [2:0] ERR_CRC   = 3'd3;
   localparam logic [2:0] ERR_LONG  = 3'd4;

   localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   localparam int unsigned RSP_DATA_WIDTH = 40;

   // One result word as it leaves the parser.
   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [7:0]  frame_type;
      logic [15:0] payload_length;
      logic [2:0]  error_code;
   } result_type;

   // Reflected CRC-32, one byte per call.
   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// ===== hdl/fprx_parser.sv =====
// Frame field parser: header, payload, CRC and end checks, one byte per cycle while byte_fire is high.
module fprx_parser
   import fprx_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       byte_fire,
   input  logic [7:0]                 rx_byte,
   output result_type                 result
);

   typedef enum logic [2:0] {
      PH_HUNT   = 3'd0,
      PH_TYPE   = 3'd1,
      PH_LEN_LO = 3'd2,
      PH_LEN_HI = 3'd3,
      PH_DATA   = 3'd4,
      PH_CRC    = 3'd5,
      PH_END    = 3'd6
   } phase_type;

   localparam logic [15:0] MaxPayload16 = 16'(MAX_PAYLOAD);

   phase_type   phase_ff, phase_in;
   logic [15:0] count_ff, count_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  type_ff, type_in;
   logic [31:0] crc_ff, crc_in;
   logic [31:0] rx_crc_ff, rx_crc_in;
   logic [7:0]  start_byte_ff, end_byte_ff;
   logic [10:0] length_limit_ff;

   logic [15:0] limit;
   logic [15:0] length_full;
   logic [15:0] count_inc;
   logic [31:0] crc_fed;
   logic [31:0] byte_lane;

   always_comb begin
      limit = {5'd0, length_limit_ff};
      if (MaxPayload16 < limit) begin
         limit = MaxPayload16;
      end
      length_full = {rx_byte, length_ff[7:0]};
      count_inc   = count_ff + 16'd1;
      crc_fed     = crc32_byte(crc_ff, rx_byte);
      byte_lane   = {24'd0, rx_byte} << {count_ff[1:0], 3'b000};
   end

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      type_in   = type_ff;
      crc_in    = crc_ff;
      rx_crc_in = rx_crc_ff;
      result    = '{valid: 1'b0, kind: KIND_DATA, payload_byte: 8'd0,
                    frame_type: type_ff, payload_length: length_ff, error_code: ERR_NONE};
      case (phase_ff)
         PH_TYPE: begin
            type_in  = rx_byte;
            crc_in   = crc_fed;
            phase_in = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            length_in = {8'd0, rx_byte};
            crc_in    = crc_fed;
            phase_in  = PH_LEN_HI;
         end
         PH_LEN_HI: begin
            length_in = length_full;
            crc_in    = crc_fed;
            count_in  = 16'd0;
            if (length_full > limit) begin
               phase_in              = PH_HUNT;
               result.valid          = 1'b1;
               result.kind           = KIND_REJECT;
               result.payload_length = length_full;
               result.error_code     = ERR_LONG;
            end else begin
               phase_in = (length_full == 16'd0) ? PH_CRC : PH_DATA;
            end
         end
         PH_DATA: begin
            crc_in = crc_fed;
            if (count_inc >= length_ff) begin
               count_in = 16'd0;
               phase_in = PH_CRC;
            end else begin
               count_in = count_inc;
            end
            result.valid        = 1'b1;
            result.kind         = KIND_DATA;
            result.payload_byte = rx_byte;
         end
         PH_CRC: begin
            rx_crc_in = rx_crc_ff | byte_lane;
            if (count_inc >= 16'd4) begin
               count_in = 16'd0;
               phase_in = PH_END;
            end else begin
               count_in = count_inc;
            end
         end
         PH_END: begin
            phase_in     = PH_HUNT;
            result.valid = 1'b1;
            if (rx_byte != end_byte_ff) begin
               result.kind       = KIND_REJECT;
               result.error_code = ERR_END;
            end else if ((crc_ff ^ CRC_INIT) != rx_crc_ff) begin
               result.kind       = KIND_REJECT;
               result.error_code = ERR_CRC;
            end else begin
               result.kind = KIND_ACCEPT;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte != start_byte_ff) begin
               result.valid          = 1'b1;
               result.kind           = KIND_REJECT;
               result.frame_type     = 8'd0;
               result.payload_length = 16'd0;
               result.error_code     = ERR_START;
            end else begin
               crc_in    = crc32_byte(CRC_INIT, rx_byte);
               rx_crc_in = 32'd0;
               count_in  = 16'd0;
               length_in = 16'd0;
               type_in   = 8'd0;
               phase_in  = PH_TYPE;
            end
         end
      endcase
      result.valid = result.valid & byte_fire;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HUNT;
         count_ff        <= 16'd0;
         length_ff       <= 16'd0;
         type_ff         <= 8'd0;
         crc_ff          <= CRC_INIT;
         rx_crc_ff       <= 32'd0;
         start_byte_ff   <= START_BYTE_RESET;
         end_byte_ff     <= END_BYTE_RESET;
         length_limit_ff <= LENGTH_LIMIT_RESET;
      end else begin
         if (byte_fire) begin
            phase_ff  <= phase_in;
            count_ff  <= count_in;
            length_ff <= length_in;
            type_ff   <= type_in;
            crc_ff    <= crc_in;
            rx_crc_ff <= rx_crc_in;
         end
         if (csr_we) begin
            case (csr_index)
               CSR_START_BYTE:   start_byte_ff   <= csr_wdata[7:0];
               CSR_END_BYTE:     end_byte_ff     <= csr_wdata[7:0];
               CSR_LENGTH_LIMIT: length_limit_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== hdl/fprx_out_reg.sv =====
// Result register: hold a word until the consumer takes it, refill in the same cycle.
module fprx_out_reg
   import fprx_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  result_type                result,
   output logic                      load_ok,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   output logic [1:0]                rsp_tuser
);

   logic       valid_ff;
   result_type word_ff;

   assign load_ok    = !valid_ff || rsp_tready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = word_ff.kind;
   assign rsp_tdata  = {5'd0, word_ff.error_code, word_ff.payload_length,
                        word_ff.frame_type, word_ff.payload_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load_ok) begin
         valid_ff <= result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load_ok && result.valid) begin
         word_ff <= result;
      end
   end

endmodule

// ===== hdl/framed_packet_receiver_crc32_core.sv =====
// Top level of the framed packet receiver with CRC-32 check.
//
//   channel | direction | word contents (lowest bit first)
//   req_*   | in        | tdata: rx_byte[7:0]
//   rsp_*   | out       | tdata: payload_byte, frame_type, payload_length, error_code;
//           |           | tuser: kind
//   csr_*   | in        | write enable, register index, write data (no read-back)
//
// One byte is taken per cycle while req_tready is high; its result, if any, shows on rsp_* the next cycle.
// The frame state and the bytewise CRC update sit in one register stage, so a
// byte never waits for the one before it.
// Reset is synchronous and active high; it returns the parser to hunting and
// restores the marker and length-limit registers to their defaults.
// A stalled result holds the input: req_tready drops only while a word waits
// and rsp_tready is low.
module framed_packet_receiver_crc32_core
   import fprx_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = MAX_PAYLOAD_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   // input byte stream
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [7:0]                 req_tdata,   // [7:0] rx_byte
   // result stream
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [RSP_DATA_WIDTH-1:0]  rsp_tdata,   // [7:0] payload_byte, [15:8] frame_type,
                                                   // [31:16] payload_length, [34:32] error_code
   output logic [1:0]                 rsp_tuser,   // [1:0] kind
   // register writes
   input  logic                       csr_we,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata
);

   result_type result;
   logic       load_ok;
   logic       byte_fire;

   // Take a byte whenever the result register can absorb what it produces.
   assign req_tready = load_ok;
   assign byte_fire  = req_tvalid && req_tready;

   fprx_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .byte_fire (byte_fire),
      .rx_byte   (req_tdata),
      .result    (result)
   );

   fprx_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .result     (result),
      .load_ok    (load_ok),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== hdl/fprx_checker.sv =====
// Port-level checks for the packet receiver, bound to the top level.
module fprx_checker
   import fprx_pkg::*;
(
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tready,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [RSP_DATA_WIDTH-1:0] rsp_tdata,
   input logic [1:0]                rsp_tuser
);

   // A stalled result word holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // A waiting word that is not taken stops the byte stream.
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted with result register full");

   // Payload words never carry an error code.
   a_data_no_error: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DATA |-> rsp_tdata[34:32] == ERR_NONE)
      else $error("payload word carries an error code");

   // Verdicts carry a zero payload byte, and a reject always names a cause.
   a_verdict_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_DATA |->
         rsp_tdata[7:0] == 8'd0 &&
         ((rsp_tuser == KIND_ACCEPT && rsp_tdata[34:32] == ERR_NONE) ||
          (rsp_tuser == KIND_REJECT && rsp_tdata[34:32] != ERR_NONE)))
      else $error("malformed verdict word");

endmodule

bind framed_packet_receiver_crc32_core fprx_checker u_fprx_checker (.*);

// ===== sim/framed_packet_receiver_crc32_core_tb.sv =====
// Self-checking testbench for the framed packet receiver: random frames, idling and a frame model.
`timescale 1ns / 1ps

module framed_packet_receiver_crc32_core_tb;
   import fprx_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400_000;
   localparam int unsigned GAP_MAX     = 18;
   localparam int unsigned DRAIN_WAIT  = 4;

   // parser position within a frame
   typedef enum logic [2:0] {
      ST_HUNT, ST_TYPE, ST_LEN_LO, ST_LEN_HI, ST_DATA, ST_CRC, ST_END
   } rx_phase_type;

   // ways a generated frame is spoilt
   typedef enum logic [1:0] {
      FAULT_NONE, FAULT_END, FAULT_CRC, FAULT_BOTH
   } frame_fault_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  payload_byte;
      logic [7:0]  frame_type;
      logic [15:0] payload_length;
      logic [2:0]  error_code;
   } rx_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;     // [7:0] rx_byte
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;          // [7:0] payload_byte, [15:8] frame_type,
                                                  // [31:16] payload_length, [34:32] error_code
   logic [1:0]                rsp_tuser;          // [1:0] kind
   logic                      csr_we = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   // bytes still to be put on the line, and words the receiver owes us
   logic [7:0]  line_bytes[$];
   rx_word_type predicted_words[$];
   int unsigned queued_count = 0;

   // shadow registers
   logic [7:0]  cfg_start;
   logic [7:0]  cfg_end;
   logic [10:0] cfg_limit;

   // frame model state
   rx_phase_type fr_phase;
   logic [15:0] fr_count;
   logic [15:0] fr_length;
   logic [7:0]  fr_type;
   logic [31:0] fr_crc;
   logic [31:0] fr_rx_crc;

   bit          hold_off = 1'b0;
   bit          send_burst = 1'b0;
   bit          rsp_burst = 1'b0;
   int unsigned send_wait = 0;
   int unsigned rsp_wait = 0;
   int unsigned mismatch_count = 0;
   int unsigned cycle_count = 0;

   framed_packet_receiver_crc32_core #(
      .MAX_PAYLOAD(MAX_PAYLOAD_DEFAULT)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // Bit-serial reflected CRC-32, least significant data bit first.
   function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         if (c[0] ^ data[i]) c = (c >> 1) ^ CRC_POLY;
         else c = c >> 1;
      end
      return c;
   endfunction

   // The length check uses the tighter of the register and the build-time cap.
   function automatic int unsigned eff_limit();
      return (cfg_limit < MAX_PAYLOAD_DEFAULT) ? cfg_limit : MAX_PAYLOAD_DEFAULT;
   endfunction

   function automatic int unsigned draw_gap(input bit burst);
      return burst ? 0 : $urandom_range(0, GAP_MAX);
   endfunction

   function automatic void push_word(input logic [1:0] kind, input logic [7:0] data,
                                     input logic [7:0] ftype, input logic [15:0] flen,
                                     input logic [2:0] err);
      rx_word_type w;
      w.kind           = kind;
      w.payload_byte   = data;
      w.frame_type     = ftype;
      w.payload_length = flen;
      w.error_code     = err;
      predicted_words.push_back(w);
   endfunction

   function automatic void reset_frame_model();
      cfg_start = START_BYTE_RESET;
      cfg_end   = END_BYTE_RESET;
      cfg_limit = LENGTH_LIMIT_RESET;
      fr_phase  = ST_HUNT;
      fr_count  = '0;
      fr_length = '0;
      fr_type   = '0;
      fr_crc    = CRC_INIT;
      fr_rx_crc = '0;
   endfunction

   // Advance the frame model by one received byte and queue any word it yields.
   function automatic void parse_byte(input logic [7:0] b);
      case (fr_phase)
         ST_TYPE: begin
            fr_type  = b;
            fr_crc   = crc32_step(fr_crc, b);
            fr_phase = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            fr_length = {8'd0, b};
            fr_crc    = crc32_step(fr_crc, b);
            fr_phase  = ST_LEN_HI;
         end
         ST_LEN_HI: begin
            fr_length[15:8] = b;
            fr_crc          = crc32_step(fr_crc, b);
            fr_count        = '0;
            if (fr_length > eff_limit()) begin
               fr_phase = ST_HUNT;
               push_word(KIND_REJECT, 8'd0, fr_type, fr_length, ERR_LONG);
            end else begin
               fr_phase = (fr_length == 16'd0) ? ST_CRC : ST_DATA;
            end
         end
         ST_DATA: begin
            fr_crc   = crc32_step(fr_crc, b);
            fr_count = fr_count + 16'd1;
            if (fr_count >= fr_length) begin
               fr_count = '0;
               fr_phase = ST_CRC;
            end
            push_word(KIND_DATA, b, fr_type, fr_length, ERR_NONE);
         end
         ST_CRC: begin
            fr_rx_crc = fr_rx_crc | ({24'd0, b} << (8 * fr_count[1:0]));
            fr_count  = fr_count + 16'd1;
            if (fr_count >= 16'd4) begin
               fr_count = '0;
               fr_phase = ST_END;
            end
         end
         ST_END: begin
            fr_phase = ST_HUNT;
            // a wrong end marker outranks a wrong CRC
            if (b != cfg_end)
               push_word(KIND_REJECT, 8'd0, fr_type, fr_length, ERR_END);
            else if (~fr_crc != fr_rx_crc)
               push_word(KIND_REJECT, 8'd0, fr_type, fr_length, ERR_CRC);
            else
               push_word(KIND_ACCEPT, 8'd0, fr_type, fr_length, ERR_NONE);
         end
         default: begin
            fr_phase = ST_HUNT;
            if (b != cfg_start) begin
               push_word(KIND_REJECT, 8'd0, 8'd0, 16'd0, ERR_START);
            end else begin
               fr_crc    = crc32_step(CRC_INIT, b);
               fr_rx_crc = '0;
               fr_count  = '0;
               fr_length = '0;
               fr_type   = '0;
               fr_phase  = ST_TYPE;
            end
         end
      endcase
   endfunction

   task automatic check_word(input logic [1:0] kind_got,
                             input logic [RSP_DATA_WIDTH-1:0] data_got);
      rx_word_type w;
      if (predicted_words.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("unexpected word: kind=%0d data=%010h", kind_got, data_got);
         return;
      end
      w = predicted_words.pop_front();
      if (kind_got != w.kind || data_got[7:0] != w.payload_byte ||
          data_got[15:8] != w.frame_type || data_got[31:16] != w.payload_length ||
          data_got[34:32] != w.error_code || data_got[RSP_DATA_WIDTH-1:35] != '0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display({"mismatch: exp kind=%0d byte=%02h type=%02h len=%0d err=%0d",
                      " | got kind=%0d byte=%02h type=%02h len=%0d err=%0d pad=%0h"},
                     w.kind, w.payload_byte, w.frame_type, w.payload_length, w.error_code,
                     kind_got, data_got[7:0], data_got[15:8], data_got[31:16],
                     data_got[34:32], data_got[RSP_DATA_WIDTH-1:35]);
      end
   endtask

   // Sender: present the next line byte, hold it while stalled, idle between bytes.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_wait = 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) parse_byte(req_tdata);
         if (send_wait > 0) begin
            send_wait--;
            req_tvalid <= 1'b0;
         end else if (line_bytes.size() != 0 && !hold_off) begin
            req_tdata  <= line_bytes.pop_front();
            req_tvalid <= 1'b1;
            if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
            send_wait = draw_gap(send_burst);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: check each word taken, then stall for a drawn number of cycles.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_word(rsp_tuser, rsp_tdata);
            if ($urandom_range(0, 49) == 0) rsp_burst = !rsp_burst;
            rsp_wait = draw_gap(rsp_burst);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: drop out if the run hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic queue_byte(input logic [7:0] b);
      line_bytes.push_back(b);
      queued_count++;
   endtask

   // Build one frame for the current register settings; drop trailing bytes to truncate it.
   // An over-long length yields the header alone, as the receiver goes back to hunting.
   task automatic queue_frame(input logic [7:0] ftype, input logic [15:0] flen,
                              input frame_fault_type fault, input int unsigned drop);
      logic [7:0]  frame_q[$];
      logic [31:0] crc;
      frame_q.push_back(cfg_start);
      frame_q.push_back(ftype);
      frame_q.push_back(flen[7:0]);
      frame_q.push_back(flen[15:8]);
      if (flen <= eff_limit()) begin
         for (int i = 0; i < flen; i++) frame_q.push_back(8'($urandom));
         crc = CRC_INIT;
         foreach (frame_q[i]) crc = crc32_step(crc, frame_q[i]);
         crc = ~crc;
         if (fault == FAULT_CRC || fault == FAULT_BOTH)
            crc = crc ^ (32'd1 << $urandom_range(0, 31));
         for (int i = 0; i < 4; i++) frame_q.push_back(crc[8*i +: 8]);
         if (fault == FAULT_END || fault == FAULT_BOTH)
            frame_q.push_back(cfg_end ^ 8'($urandom_range(1, 255)));
         else
            frame_q.push_back(cfg_end);
      end
      if (drop >= frame_q.size()) drop = frame_q.size() - 1;
      for (int i = 0; i < frame_q.size() - drop; i++) queue_byte(frame_q[i]);
   endtask

   function automatic frame_fault_type draw_fault();
      case ($urandom_range(0, 9))
         7:       return FAULT_END;
         8:       return FAULT_CRC;
         9:       return FAULT_BOTH;
         default: return FAULT_NONE;
      endcase
   endfunction

   // Mostly complete frames with random content, some with a bad end or CRC; the rest
   // over-long headers, line noise and truncated frames.
   task automatic queue_traffic(input int unsigned budget);
      int unsigned target;
      int unsigned pick;
      int unsigned lim;
      logic [15:0] flen;
      target = queued_count + budget;
      while (queued_count < target) begin
         pick = $urandom_range(0, 99);
         lim  = eff_limit();
         if (pick < 70) begin
            if ($urandom_range(0, 9) == 0) flen = 16'($urandom_range(0, (lim < 64) ? lim : 64));
            else flen = 16'($urandom_range(0, (lim < 12) ? lim : 12));
            queue_frame(8'($urandom), flen, draw_fault(), 0);
         end else if (pick < 80) begin
            flen = ($urandom_range(0, 1) == 0) ? 16'(lim + 1) : 16'($urandom_range(lim + 1, 65535));
            queue_frame(8'($urandom), flen, FAULT_NONE, 0);
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 4)) queue_byte(8'($urandom));
         end else begin
            flen = 16'($urandom_range(0, (lim < 8) ? lim : 8));
            queue_frame(8'($urandom), flen, FAULT_NONE, $urandom_range(1, 12));
         end
      end
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx, input logic [10:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_START_BYTE:   cfg_start = value[7:0];
         CSR_END_BYTE:     cfg_end   = value[7:0];
         CSR_LENGTH_LIMIT: cfg_limit = value;
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Wait until every byte is sent and every word is back, then let the pipe settle.
   task automatic wait_idle();
      while (line_bytes.size() != 0 || req_tvalid || predicted_words.size() != 0)
         @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   initial begin
      reset_frame_model();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: noise at both byte extremes, a one-byte frame, an empty frame
      // with a broken CRC, and the largest possible length field.
      queue_byte(8'h00);
      queue_byte(8'hFF);
      queue_frame(8'hFF, 16'd1, FAULT_NONE, 0);
      queue_frame(8'h00, 16'd0, FAULT_CRC, 0);
      queue_frame(8'h7E, 16'hFFFF, FAULT_NONE, 0);
      queue_traffic(170);

      // Hold the sender midway until every outstanding word has come back.
      while (line_bytes.size() > 85) @(negedge clock);
      hold_off = 1'b1;
      while (req_tvalid || predicted_words.size() != 0) @(negedge clock);
      hold_off = 1'b0;
      wait_idle();

      // Zero start marker, all-ones end marker, no payload allowed.
      write_csr(CSR_START_BYTE, 11'h000);
      write_csr(CSR_END_BYTE, 11'h0FF);
      write_csr(CSR_LENGTH_LIMIT, 11'd0);
      @(negedge clock);
      queue_traffic(170);
      wait_idle();

      // Limit register above the build-time cap: the cap rules.
      write_csr(CSR_START_BYTE, 11'h0FF);
      write_csr(CSR_END_BYTE, 11'h000);
      write_csr(CSR_LENGTH_LIMIT, 11'h7FF);
      @(negedge clock);
      queue_frame(8'hA5, 16'(MAX_PAYLOAD_DEFAULT + 1), FAULT_NONE, 0);
      queue_traffic(170);
      wait_idle();

      // Random markers and a small limit.
      write_csr(CSR_START_BYTE, 11'($urandom_range(0, 255)));
      write_csr(CSR_END_BYTE, 11'($urandom_range(0, 255)));
      write_csr(CSR_LENGTH_LIMIT, 11'($urandom_range(1, 40)));
      @(negedge clock);
      queue_traffic(170);
      wait_idle();

      // Back to the defaults, written explicitly.
      write_csr(CSR_START_BYTE, 11'(START_BYTE_RESET));
      write_csr(CSR_END_BYTE, 11'(END_BYTE_RESET));
      write_csr(CSR_LENGTH_LIMIT, LENGTH_LIMIT_RESET);
      @(negedge clock);
      queue_traffic(170);
      wait_idle();

      repeat (10) @(negedge clock);
      if (mismatch_count == 0 && predicted_words.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/fprx_pkg.sv
hdl/fprx_parser.sv
hdl/fprx_out_reg.sv
hdl/framed_packet_receiver_crc32_core.sv
hdl/fprx_checker.sv
sim/framed_packet_receiver_crc32_core_tb.sv
